// ===== hw/rtl/sha1_stream_hasher_defines.svh =====
// Assertion macros for the checker file of the hasher.
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sha1 check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sha1 check failed: next-cycle implication");

`endif

// ===== hw/rtl/sha1_pkg.sv =====
package sha1_pkg;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_OFFSET = 6'd56;
  localparam logic [5:0]  LAST_POS   = 6'd63;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [2:0]  LAST_WORD  = 3'd4;

  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } round_grp_t;

  typedef enum logic [1:0] {
    BSEL_MSG,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic       absorb;
    byte_sel_t  byte_sel;
    logic       count_len;
    logic       load_work;
    logic       round;
    round_grp_t grp;
    logic       add_chain;
    logic       reset_hash;
    logic [2:0] out_sel;
  } sha1_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } sha1_status_t;

  function automatic logic [31:0] round_const(input round_grp_t grp);
    logic [31:0] k;
    case (grp)
      GRP_CH:   k = 32'h5A827999;
      GRP_PAR1: k = 32'h6ED9EBA1;
      GRP_MAJ:  k = 32'h8F1BBCDC;
      GRP_PAR2: k = 32'hCA62C1D6;
      default:  k = 32'h5A827999;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      3'd4:    v = 32'hC3D2E1F0;
      default: v = 32'h67452301;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/sha1_stream_hasher.sv =====
// Channel   Direction  tdata                tuser              tlast
// s_*       in         [7:0] data_byte      [0] byte_present   message_end
// m_*       out        [31:0] digest_word   [2:0] word_index   digest_last
//
// A byte item is absorbed as it is taken; the item that completes a 64-byte block
// then runs 80 rounds on the single round unit plus the chaining add.
// An item with the end mark then absorbs the pad and length bytes, runs one or two
// block compressions, then gives five digest words, one per cycle while m_tready.
// Reset (rst, synchronous) loads the initial chaining words and clears counts.
// No input item is taken during compression, padding or digest output.
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast
);

  sha1_pkg::sha1_cmd_t    cmd;
  sha1_pkg::sha1_status_t status;

  sha1_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .byte_present (s_tuser),
    .message_end  (s_tlast),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .cmd          (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_tdata),
    .status      (status),
    .digest_word (m_tdata)
  );

  assign m_tuser = cmd.out_sel;
  assign m_tlast = (cmd.out_sel == sha1_pkg::LAST_WORD);

endmodule

// ===== hw/rtl/sha1_dp.sv =====
module sha1_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sha1_pkg::sha1_cmd_t   cmd,
  input  logic [7:0]            data_byte,
  output sha1_pkg::sha1_status_t status,
  output logic [31:0]           digest_word
);

  // Block buffer and message schedule share one 512-bit shift line.
  // The oldest word sits in the top 32 bits.
  logic [511:0] blk;
  logic [31:0]  h [5];
  logic [31:0]  a, b, c, d, e;
  logic [5:0]   fill;
  logic [63:0]  bit_len;

  logic [7:0]  in_byte;
  logic [31:0] f_val;
  logic [31:0] tmp;
  logic [31:0] w_new;
  logic [31:0] w0, w2, w8, w13;

  assign w0  = blk[511:480];
  assign w2  = blk[447:416];
  assign w8  = blk[255:224];
  assign w13 = blk[95:64];

  always_comb begin
    w_new = w13 ^ w8 ^ w2 ^ w0;
    w_new = {w_new[30:0], w_new[31]};
  end

  always_comb begin
    case (cmd.byte_sel)
      sha1_pkg::BSEL_MSG:  in_byte = data_byte;
      sha1_pkg::BSEL_PAD:  in_byte = sha1_pkg::PAD_BYTE;
      sha1_pkg::BSEL_ZERO: in_byte = 8'h00;
      // Length bytes go out most significant first at positions 56..63.
      sha1_pkg::BSEL_LEN:  in_byte = bit_len[{~fill[2:0], 3'b000} +: 8];
      default:             in_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.grp)
      sha1_pkg::GRP_CH:  f_val = (b & c) | (~b & d);
      sha1_pkg::GRP_MAJ: f_val = (b & c) | (b & d) | (c & d);
      default:           f_val = b ^ c ^ d;
    endcase
    tmp = {a[26:0], a[31:27]} + f_val + e + sha1_pkg::round_const(cmd.grp) + w0;
  end

  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      blk <= {blk[503:0], in_byte};
    end else if (cmd.round) begin
      blk <= {blk[479:0], w_new};
    end

    if (cmd.load_work) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end

    if (rst || cmd.reset_hash) begin
      for (int i = 0; i < 5; i++) begin
        h[i] <= sha1_pkg::init_word(3'(i));
      end
      fill    <= '0;
      bit_len <= '0;
    end else begin
      if (cmd.add_chain) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (cmd.absorb) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_len) begin
        bit_len <= bit_len + 64'd8;
      end
    end
  end

  assign status.fill = fill;
  assign digest_word = h[cmd.out_sel];

endmodule

// ===== hw/rtl/sha1_ctrl.sv =====
module sha1_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   byte_present,
  input  logic                   message_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  sha1_pkg::sha1_status_t status,
  output sha1_pkg::sha1_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_80,
    PH_ZERO,
    PH_LEN
  } pad_phase_t;

  state_t     state;
  pad_phase_t phase;
  logic [6:0] rnd;
  logic       finishing;
  logic       final_blk;
  logic [2:0] out_sel;

  logic full;
  logic is_len;

  assign full = (status.fill == sha1_pkg::LAST_POS);
  // Zero padding stops once the block reaches the length field.
  assign is_len = (phase == PH_LEN) ||
                  ((phase == PH_ZERO) && (status.fill == sha1_pkg::LEN_OFFSET));

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd            = '0;
    cmd.byte_sel   = sha1_pkg::BSEL_MSG;
    cmd.grp        = sha1_pkg::GRP_CH;
    cmd.out_sel    = out_sel;
    case (state)
      S_IDLE: begin
        cmd.absorb    = in_valid && byte_present;
        cmd.count_len = in_valid && byte_present;
        cmd.load_work = in_valid && byte_present && full;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (rnd < 7'd20) begin
          cmd.grp = sha1_pkg::GRP_CH;
        end else if (rnd < 7'd40) begin
          cmd.grp = sha1_pkg::GRP_PAR1;
        end else if (rnd < 7'd60) begin
          cmd.grp = sha1_pkg::GRP_MAJ;
        end else begin
          cmd.grp = sha1_pkg::GRP_PAR2;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
      end
      S_PAD: begin
        cmd.absorb    = 1'b1;
        cmd.load_work = full;
        if (phase == PH_80) begin
          cmd.byte_sel = sha1_pkg::BSEL_PAD;
        end else if (is_len) begin
          cmd.byte_sel = sha1_pkg::BSEL_LEN;
        end else begin
          cmd.byte_sel = sha1_pkg::BSEL_ZERO;
        end
      end
      S_OUT: begin
        cmd.reset_hash = out_ready && (out_sel == sha1_pkg::LAST_WORD);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_80;
      rnd       <= '0;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      out_sel   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            phase     <= PH_80;
            finishing <= message_end;
            if (byte_present && full) begin
              rnd   <= '0;
              state <= S_ROUND;
            end else if (message_end) begin
              state <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == sha1_pkg::LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (!finishing) begin
            state <= S_IDLE;
          end else if (final_blk) begin
            out_sel <= '0;
            state   <= S_OUT;
          end else begin
            state <= S_PAD;
          end
        end
        S_PAD: begin
          if (phase == PH_80) begin
            phase <= PH_ZERO;
          end else if (is_len) begin
            phase <= PH_LEN;
          end
          if (full) begin
            final_blk <= is_len;
            rnd       <= '0;
            state     <= S_ROUND;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (out_sel == sha1_pkg::LAST_WORD) begin
              finishing <= 1'b0;
              final_blk <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out_sel <= out_sel + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/sha1_stream_hasher_chk.sv =====
`include "sha1_stream_hasher_defines.svh"

module sha1_stream_hasher_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled digest word holds its value.
  `SHA1_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Input is never taken while a digest is being delivered.
  `SHA1_ASSERT_SAME(a_no_overlap, clk, rst, m_tvalid, !s_tready)

  // The last mark sits on word four and nowhere else.
  `SHA1_ASSERT_SAME(a_last_pos, clk, rst, m_tvalid, m_tlast == (m_tuser == 3'd4))

  // Words follow in order without gaps.
  `SHA1_ASSERT_NEXT(a_word_seq, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))

  // After the last word the block goes back to taking input.
  `SHA1_ASSERT_NEXT(a_back_idle, clk, rst, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready)

endmodule

bind sha1_stream_hasher sha1_stream_hasher_chk u_chk (.*);

// ===== tb/tb_sha1_stream_hasher.sv =====
module tb_sha1_stream_hasher;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // Bit-exact SHA-1 of the byte stream; holds the digest words still to come.
  class sha1_digest_calc_t;
    logic [31:0]  chain[5];
    logic [7:0]   blk[64];
    int           fill;
    logic [63:0]  bit_len;
    digest_word_t pending_words[$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hEFCDAB89;
      chain[2] = 32'h98BADCFE;
      chain[3] = 32'h10325476;
      chain[4] = 32'hC3D2E1F0;
      fill = 0;
      bit_len = '0;
    endfunction

    function void compress();
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) begin
        w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      end
      for (int r = 16; r < 80; r++) begin
        t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
        w[r] = {t[30:0], t[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[r];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void absorb(logic [7:0] v);
      blk[fill] = v;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void absorb_item(logic [7:0] data, logic present, logic msg_end);
      logic [63:0]  len;
      digest_word_t dw;
      if (present) begin
        bit_len += 64'd8;
        absorb(data);
      end
      if (msg_end) begin
        len = bit_len;
        absorb(sha1_pkg::PAD_BYTE);
        // No room left for the length field: pad out this block first.
        if (fill > sha1_pkg::LEN_OFFSET) begin
          while (fill != 0) absorb(8'h00);
        end
        while (fill < sha1_pkg::LEN_OFFSET) absorb(8'h00);
        for (int i = 0; i < 8; i++) absorb(len[63 - 8*i -: 8]);
        for (int j = 0; j < 5; j++) begin
          dw.word = chain[j];
          dw.idx = 3'(j);
          dw.last = (3'(j) == sha1_pkg::LAST_WORD);
          pending_words.push_back(dw);
        end
        restart();
      end
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
      digest_word_t dw;
      if (pending_words.size() == 0) begin
        $error("unexpected digest word %h (index %0d)", word, idx);
        errors++;
        return;
      end
      dw = pending_words.pop_front();
      if (word !== dw.word) begin
        $error("digest_word mismatch: expected %h, actual %h", dw.word, word);
        errors++;
      end
      if (idx !== dw.idx) begin
        $error("word_index mismatch: expected %0d, actual %0d", dw.idx, idx);
        errors++;
      end
      if (last !== dw.last) begin
        $error("digest_last mismatch: expected %0b, actual %0b", dw.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  sha1_digest_calc_t calc = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int byte_items = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  sha1_stream_hasher uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) calc.absorb_item(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) calc.check_word(m_tdata, m_tuser, m_tlast);
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] data, input logic present, input logic msg_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= present;
    s_tlast <= msg_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (present || msg_end) byte_items++;
  endtask

  // The first edge lets the monitor note the item accepted at this edge.
  task automatic wait_drained();
    @(posedge clk);
    while (calc.pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    bit end_on_byte;
    end_on_byte = $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && end_on_byte);
    end
    if (len == 0 || !end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic set_idling();
    if (byte_items < 120) begin
      send_idle_pct = 37;
      recv_idle_pct = 85;
    end else if (byte_items < 230) begin
      send_idle_pct = 85;
      recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    int len;
    int pick;
    int msg_count;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty message straight after reset, then an ignored item.
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    // Byte extremes, end mark riding on the last byte.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    // End mark on its own item after some bytes.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    // Back-to-back empty message right after a digest.
    send_item(8'h3C, 1'b0, 1'b1);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);
    s_tvalid <= 1'b0;
    wait_drained();

    byte_items = 0;
    msg_count = 0;
    while (byte_items < 320) begin
      set_idling();
      pick = $urandom_range(9);
      if (pick < 5) len = $urandom_range(12);
      else if (pick < 9) len = $urandom_range(72, 52);
      else len = $urandom_range(135, 110);
      if (len > 320 - byte_items) len = 320 - byte_items;
      // The receiver stalls for a long time while bytes keep coming.
      if (msg_count == 1) hold_req = 1'b1;
      send_message(len);
      msg_count++;
      if (msg_count == 5) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
    end
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (calc.errors == 0 && calc.pending_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_dp.sv
hw/rtl/sha1_ctrl.sv
hw/rtl/sha1_stream_hasher.sv
hw/rtl/sha1_stream_hasher_chk.sv
tb/tb_sha1_stream_hasher.sv
